// ===== sv/kalman_filter_pos_vel_bias_macros.svh =====
// ----------------------------------------------------------------------------
// kalman filter assertion macros
// shared property shorthands for the filter's checker
// ----------------------------------------------------------------------------
`ifndef KALMAN_FILTER_POS_VEL_BIAS_MACROS_SVH
`define KALMAN_FILTER_POS_VEL_BIAS_MACROS_SVH

// same-cycle implication, off during reset
`define KFPVB_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kalman filter check failed");

// next-cycle implication, off during reset
`define KFPVB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kalman filter check failed");

// next-cycle implication that also holds across reset
`define KFPVB_ASSERT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("kalman filter check failed");

`endif

// ===== sv/kfpvb_pkg.sv =====
// ----------------------------------------------------------------------------
// kfpvb_pkg
// types, codes and the predict step table of the kalman filter
// ----------------------------------------------------------------------------
package kfpvb_pkg;

   // request codes
   localparam logic [1:0] REQ_CLEAR   = 2'd0;
   localparam logic [1:0] REQ_PREDICT = 2'd1;
   localparam logic [1:0] REQ_UPD_POS = 2'd2;
   localparam logic [1:0] REQ_UPD_VEL = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_NOISE_POS = 2'd0;
   localparam logic [1:0] CSR_NOISE_VEL = 2'd1;
   localparam logic [1:0] CSR_NOISE_BIAS = 2'd2;

   // predict destinations: covariance entries then estimates
   localparam logic [3:0] DST_C00  = 4'd0;
   localparam logic [3:0] DST_C01  = 4'd1;
   localparam logic [3:0] DST_C02  = 4'd2;
   localparam logic [3:0] DST_C10  = 4'd3;
   localparam logic [3:0] DST_C11  = 4'd4;
   localparam logic [3:0] DST_C12  = 4'd5;
   localparam logic [3:0] DST_C20  = 4'd6;
   localparam logic [3:0] DST_C21  = 4'd7;
   localparam logic [3:0] DST_C22  = 4'd8;
   localparam logic [3:0] DST_EST0 = 4'd9;
   localparam logic [3:0] DST_EST1 = 4'd10;

   localparam logic [4:0] LAST_STEP = 5'd30;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_W_MUL,
      ST_W_WR,
      ST_P_MUL,
      ST_P_ACC,
      ST_U_LOAD,
      ST_U_MUL,
      ST_U_DIV,
      ST_U_WAIT,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      SRC_P00, SRC_P01, SRC_P02,
      SRC_P10, SRC_P11, SRC_P12,
      SRC_P20, SRC_P21, SRC_P22,
      SRC_VEL, SRC_PURE, SRC_ZERO
   } src_type;

   // one product term of the propagation
   typedef struct packed {
      src_type    src;
      logic [1:0] pw;     // dt power: dt, dt^2, dt^3, dt^4
      logic [1:0] sh;     // extra right shift
      logic       neg;
      logic       first;
      logic       last;
      logic [3:0] dst;
   } step_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
   localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) r = 32'sh7fffffff;
      else if (v < SAT_MIN) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // term sequence; each destination is written after its last use as a source
   function automatic step_type pred_step(input logic [4:0] k);
      step_type s;
      unique case (k)
         5'd0:  s = '{SRC_VEL,  2'd0, 2'd0, 1'b0, 1'b1, 1'b0, DST_EST0};
         5'd1:  s = '{SRC_PURE, 2'd1, 2'd1, 1'b0, 1'b0, 1'b1, DST_EST0};
         5'd2:  s = '{SRC_PURE, 2'd0, 2'd0, 1'b0, 1'b1, 1'b1, DST_EST1};
         5'd3:  s = '{SRC_P01,  2'd0, 2'd0, 1'b0, 1'b1, 1'b0, DST_C00};
         5'd4:  s = '{SRC_P10,  2'd0, 2'd0, 1'b0, 1'b0, 1'b0, DST_C00};
         5'd5:  s = '{SRC_P11,  2'd1, 2'd0, 1'b0, 1'b0, 1'b0, DST_C00};
         5'd6:  s = '{SRC_P02,  2'd1, 2'd1, 1'b1, 1'b0, 1'b0, DST_C00};
         5'd7:  s = '{SRC_P20,  2'd1, 2'd1, 1'b1, 1'b0, 1'b0, DST_C00};
         5'd8:  s = '{SRC_P12,  2'd2, 2'd1, 1'b1, 1'b0, 1'b0, DST_C00};
         5'd9:  s = '{SRC_P21,  2'd2, 2'd1, 1'b1, 1'b0, 1'b0, DST_C00};
         5'd10: s = '{SRC_P22,  2'd3, 2'd2, 1'b0, 1'b0, 1'b1, DST_C00};
         5'd11: s = '{SRC_P11,  2'd0, 2'd0, 1'b0, 1'b1, 1'b0, DST_C01};
         5'd12: s = '{SRC_P02,  2'd0, 2'd0, 1'b1, 1'b0, 1'b0, DST_C01};
         5'd13: s = '{SRC_P12,  2'd1, 2'd0, 1'b1, 1'b0, 1'b0, DST_C01};
         5'd14: s = '{SRC_P21,  2'd1, 2'd1, 1'b1, 1'b0, 1'b0, DST_C01};
         5'd15: s = '{SRC_P22,  2'd2, 2'd1, 1'b0, 1'b0, 1'b1, DST_C01};
         5'd16: s = '{SRC_P12,  2'd0, 2'd0, 1'b0, 1'b1, 1'b0, DST_C02};
         5'd17: s = '{SRC_P22,  2'd1, 2'd1, 1'b1, 1'b0, 1'b1, DST_C02};
         5'd18: s = '{SRC_P11,  2'd0, 2'd0, 1'b0, 1'b1, 1'b0, DST_C10};
         5'd19: s = '{SRC_P20,  2'd0, 2'd0, 1'b1, 1'b0, 1'b0, DST_C10};
         5'd20: s = '{SRC_P21,  2'd1, 2'd0, 1'b1, 1'b0, 1'b0, DST_C10};
         5'd21: s = '{SRC_P12,  2'd1, 2'd1, 1'b1, 1'b0, 1'b0, DST_C10};
         5'd22: s = '{SRC_P22,  2'd2, 2'd1, 1'b0, 1'b0, 1'b1, DST_C10};
         5'd23: s = '{SRC_P21,  2'd0, 2'd0, 1'b0, 1'b1, 1'b0, DST_C20};
         5'd24: s = '{SRC_P22,  2'd1, 2'd1, 1'b1, 1'b0, 1'b1, DST_C20};
         5'd25: s = '{SRC_P12,  2'd0, 2'd0, 1'b1, 1'b1, 1'b0, DST_C11};
         5'd26: s = '{SRC_P21,  2'd0, 2'd0, 1'b1, 1'b0, 1'b0, DST_C11};
         5'd27: s = '{SRC_P22,  2'd1, 2'd0, 1'b0, 1'b0, 1'b1, DST_C11};
         5'd28: s = '{SRC_P22,  2'd0, 2'd0, 1'b1, 1'b1, 1'b1, DST_C12};
         5'd29: s = '{SRC_P22,  2'd0, 2'd0, 1'b1, 1'b1, 1'b1, DST_C21};
         5'd30: s = '{SRC_ZERO, 2'd0, 2'd0, 1'b0, 1'b1, 1'b1, DST_C22};
         default: s = '{SRC_ZERO, 2'd0, 2'd0, 1'b0, 1'b1, 1'b1, DST_C22};
      endcase
      return s;
   endfunction

endpackage

// ===== sv/kfpvb_mul.sv =====
// ----------------------------------------------------------------------------
// kfpvb_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module kfpvb_mul (
   input  logic               clock,
   input  logic signed [32:0] mul_a,
   input  logic signed [32:0] mul_b,
   output logic signed [65:0] mul_p
);

   logic signed [65:0] prod_ff;

   // one product per cycle
   always_ff @(posedge clock) begin
      prod_ff <= 66'(mul_a) * 66'(mul_b);
   end

   assign mul_p = prod_ff;

endmodule

// ===== sv/kfpvb_div.sv =====
// ----------------------------------------------------------------------------
// kfpvb_div
// bit-serial signed divider, quotient rounded toward zero
// ----------------------------------------------------------------------------
module kfpvb_div #(
   parameter int DVS_W = 39
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [63:0]       dividend,
   input  logic signed [DVS_W-1:0]  divisor,
   output kfpvb_pkg::div_stat_type  status,
   output logic signed [63:0]       quotient
);
   import kfpvb_pkg::*;

   logic                busy_ff, busy_in;
   logic                fix_ff, fix_in;
   logic                done_ff, done_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [DVS_W-1:0]    rem_ff, rem_in;
   logic [63:0]         quo_ff, quo_in;
   logic [DVS_W-1:0]    dvs_ff, dvs_in;
   logic                neg_ff, neg_in;
   logic signed [63:0]  q_ff, q_in;
   logic [DVS_W:0]      rem_sh;
   logic [DVS_W:0]      rem_sub;

   // one restoring step per cycle on magnitudes
   always_comb begin
      busy_in = busy_ff;
      fix_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      q_in    = q_ff;
      rem_sh  = {rem_ff, quo_ff[63]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[63] ? 64'(-dividend) : 64'(dividend);
         dvs_in  = divisor[DVS_W-1] ? DVS_W'(-divisor) : DVS_W'(divisor);
         neg_in  = dividend[63] ^ divisor[DVS_W-1];
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sub[DVS_W-1:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh[DVS_W-1:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         // apply the sign
         q_in    = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      q_ff   <= q_in;
   end

   assign status.busy = busy_ff | fix_ff;
   assign status.done = done_ff;
   assign quotient    = q_ff;

endmodule

// ===== sv/kalman_filter_pos_vel_bias.sv =====
// ----------------------------------------------------------------------------
// kalman_filter_pos_vel_bias
// three-state kalman filter for position, velocity and acceleration bias
// ----------------------------------------------------------------------------
// One item at a time: req_stall stays high from acceptance until the result
// item has been taken. A predict runs three multiplies for dt^2..dt^4,
// then 31 product terms through the shared multiplier. A position or velocity
// update with nonzero innovation variance makes twelve corrections, each one
// multiply and one pass of the bit-serial divider, which retires one quotient
// bit per cycle over 64 bits. The result stays in an output register until
// taken.
module kalman_filter_pos_vel_bias #(
   parameter int COV_FRAC_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] req_sample,
   input  logic [23:0]        req_delta_time,
   input  logic [30:0]        req_sensor_noise,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic               rsp_skipped,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_data
);
   import kfpvb_pkg::*;

   localparam int NSH_L  = (COV_FRAC_BITS >= 24) ? COV_FRAC_BITS - 24 : 0;
   localparam int NSH_R  = (COV_FRAC_BITS < 24) ? 24 - COV_FRAC_BITS : 0;
   localparam int NCOV_W = 31 + NSH_L;
   localparam int S_W    = NCOV_W + 2;
   localparam int ACC_W  = NCOV_W + 8;
   localparam logic signed [31:0] COV_ONE = 32'sd1 <<< COV_FRAC_BITS;

   // noise in covariance format
   function automatic logic [NCOV_W-1:0] ncov(input logic [30:0] q);
      logic [NCOV_W-1:0] w;
      w = NCOV_W'(q);
      return (w << NSH_L) >> NSH_R;
   endfunction

   state_type           state_ff, state_in;
   logic signed [31:0]  est_ff [3];
   logic signed [31:0]  est_in [3];
   logic signed [31:0]  cov_ff [9];
   logic signed [31:0]  cov_in [9];
   logic [30:0]         noise_ff [3];
   logic [23:0]         dtp_ff [4];
   logic [23:0]         dtp_in [4];
   logic                m_ff, m_in;
   logic signed [31:0]  sample_ff, sample_in;
   logic [30:0]         rn_ff, rn_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [4:0]          step_ff, step_in;
   logic [1:0]          pcnt_ff, pcnt_in;
   logic [1:0]          ui_ff, ui_in;
   logic [1:0]          uj_ff, uj_in;
   logic signed [31:0]  err_ff, err_in;
   logic signed [S_W-1:0] s_ff, s_in;
   logic signed [31:0]  col_ff [3];
   logic signed [31:0]  col_in [3];
   logic signed [31:0]  row_ff [3];
   logic signed [31:0]  row_in [3];
   logic signed [31:0]  value_ff, value_in;
   logic                skipped_ff, skipped_in;

   logic signed [32:0]  mul_a, mul_b;
   logic signed [65:0]  mul_p;
   logic                div_start;
   div_stat_type        div_stat;
   logic signed [63:0]  div_q;

   step_type            st;
   logic signed [65:0]  fl;
   logic signed [ACC_W-1:0] term, base, nz, sum;
   logic signed [31:0]  res;
   logic signed [31:0]  err_v;
   logic signed [S_W-1:0] s_v;
   logic [3:0]          uidx;
   logic                accept;

   assign accept = req_valid && !req_stall;
   assign st     = pred_step(step_ff);
   assign uidx   = 4'({ui_ff, 1'b0}) + 4'(ui_ff) + 4'(uj_ff);

   kfpvb_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   kfpvb_div #(.DVS_W(S_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_p[63:0]),
      .divisor  (s_ff),
      .status   (div_stat),
      .quotient (div_q)
   );

   // sequencer and datapath
   always_comb begin
      state_in   = state_ff;
      est_in     = est_ff;
      cov_in     = cov_ff;
      dtp_in     = dtp_ff;
      m_in       = m_ff;
      sample_in  = sample_ff;
      rn_in      = rn_ff;
      acc_in     = acc_ff;
      step_in    = step_ff;
      pcnt_in    = pcnt_ff;
      ui_in      = ui_ff;
      uj_in      = uj_ff;
      err_in     = err_ff;
      s_in       = s_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      value_in   = value_ff;
      skipped_in = skipped_ff;
      mul_a      = '0;
      mul_b      = '0;
      div_start  = 1'b0;

      // predict term arithmetic
      fl   = mul_p >>> (7'd24 + 7'(st.sh));
      term = st.neg ? -ACC_W'(fl) : ACC_W'(fl);
      if (st.dst == DST_EST0) base = ACC_W'(est_ff[0]);
      else if (st.dst == DST_EST1) base = ACC_W'(est_ff[1]);
      else base = ACC_W'(cov_ff[st.dst]);
      if (st.dst == DST_C00) nz = ACC_W'(ncov(noise_ff[0]));
      else if (st.dst == DST_C11) nz = ACC_W'(ncov(noise_ff[1]));
      else if (st.dst == DST_C22) nz = ACC_W'(ncov(noise_ff[2]));
      else nz = '0;
      sum = (st.first ? base + nz : acc_ff) + term;
      res = sat32(66'(sum));

      // update front end
      err_v = sat32(66'(sample_ff) - 66'(est_ff[{1'b0, m_ff}]));
      s_v   = S_W'(m_ff ? cov_ff[4] : cov_ff[0]) + S_W'(ncov(rn_ff));

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in  = req_sample;
               rn_in      = req_sensor_noise;
               m_in       = req_type[0];
               dtp_in[0]  = req_delta_time;
               pcnt_in    = '0;
               step_in    = '0;
               ui_in      = '0;
               uj_in      = '0;
               value_in   = '0;
               skipped_in = 1'b0;
               unique case (req_type)
                  REQ_CLEAR: begin
                     for (int i = 0; i < 3; i++) est_in[i] = '0;
                     for (int i = 0; i < 9; i++) cov_in[i] = (i % 4 == 0) ? COV_ONE : '0;
                     state_in = ST_OUT;
                  end
                  REQ_PREDICT: state_in = ST_W_MUL;
                  REQ_UPD_POS, REQ_UPD_VEL: state_in = ST_U_LOAD;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         // powers of dt
         ST_W_MUL: begin
            mul_a    = 33'(dtp_ff[pcnt_ff]);
            mul_b    = 33'(dtp_ff[0]);
            state_in = ST_W_WR;
         end
         ST_W_WR: begin
            dtp_in[pcnt_ff + 2'd1] = mul_p[47:24];
            pcnt_in  = pcnt_ff + 2'd1;
            state_in = (pcnt_ff == 2'd2) ? ST_P_MUL : ST_W_MUL;
         end
         // propagation terms
         ST_P_MUL: begin
            unique case (st.src)
               SRC_VEL:  mul_a = 33'(est_ff[1]);
               SRC_PURE: mul_a = 33'(sample_ff) - 33'(est_ff[2]);
               SRC_ZERO: mul_a = '0;
               default:  mul_a = 33'(cov_ff[st.src]);
            endcase
            mul_b    = 33'(dtp_ff[st.pw]);
            state_in = ST_P_ACC;
         end
         ST_P_ACC: begin
            acc_in = sum;
            if (st.last) begin
               if (st.dst == DST_EST0) est_in[0] = res;
               else if (st.dst == DST_EST1) est_in[1] = res;
               else cov_in[st.dst] = res;
            end
            if (step_ff == LAST_STEP) begin
               value_in = est_ff[0];
               state_in = ST_OUT;
            end else begin
               step_in  = step_ff + 5'd1;
               state_in = ST_P_MUL;
            end
         end
         // innovation, its variance and a snapshot of row and column m
         ST_U_LOAD: begin
            err_in   = err_v;
            s_in     = s_v;
            value_in = err_v;
            for (int i = 0; i < 3; i++) begin
               col_in[i] = m_ff ? cov_ff[i * 3 + 1] : cov_ff[i * 3];
               row_in[i] = m_ff ? cov_ff[3 + i] : cov_ff[i];
            end
            if (s_v == '0) begin
               skipped_in = 1'b1;
               state_in   = ST_OUT;
            end else begin
               state_in = ST_U_MUL;
            end
         end
         ST_U_MUL: begin
            mul_a    = 33'(col_ff[ui_ff]);
            mul_b    = (uj_ff == 2'd3) ? 33'(err_ff) : 33'(row_ff[uj_ff]);
            state_in = ST_U_DIV;
         end
         ST_U_DIV: begin
            div_start = 1'b1;
            state_in  = ST_U_WAIT;
         end
         ST_U_WAIT: begin
            if (div_stat.done) begin
               if (uj_ff == 2'd3) begin
                  est_in[ui_ff] = sat32(66'(est_ff[ui_ff]) + 66'(div_q));
                  uj_in = '0;
                  if (ui_ff == 2'd2) begin
                     state_in = ST_OUT;
                  end else begin
                     ui_in    = ui_ff + 2'd1;
                     state_in = ST_U_MUL;
                  end
               end else begin
                  cov_in[uidx] = sat32(66'(cov_ff[uidx]) - 66'(div_q));
                  uj_in    = uj_ff + 2'd1;
                  state_in = ST_U_MUL;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < 3; i++) est_ff[i] <= '0;
         for (int i = 0; i < 9; i++) cov_ff[i] <= (i % 4 == 0) ? COV_ONE : '0;
      end else begin
         state_ff <= state_in;
         est_ff   <= est_in;
         cov_ff   <= cov_in;
      end
      dtp_ff     <= dtp_in;
      m_ff       <= m_in;
      sample_ff  <= sample_in;
      rn_ff      <= rn_in;
      acc_ff     <= acc_in;
      step_ff    <= step_in;
      pcnt_ff    <= pcnt_in;
      ui_ff      <= ui_in;
      uj_ff      <= uj_in;
      err_ff     <= err_in;
      s_ff       <= s_in;
      col_ff     <= col_in;
      row_ff     <= row_in;
      value_ff   <= value_in;
      skipped_ff <= skipped_in;
   end

   // noise registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) noise_ff[i] <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_NOISE_POS:  noise_ff[0] <= csr_data;
            CSR_NOISE_VEL:  noise_ff[1] <= csr_data;
            CSR_NOISE_BIAS: noise_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = (state_ff == ST_OUT);
   assign rsp_value   = value_ff;
   assign rsp_skipped = skipped_ff;

endmodule

// ===== sv/kfpvb_checker.sv =====
// ----------------------------------------------------------------------------
// kfpvb_checker
// port-level checks of the kalman filter's item flow
// ----------------------------------------------------------------------------
`include "kalman_filter_pos_vel_bias_macros.svh"

module kfpvb_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_value,
   input logic               rsp_skipped
);

   // no result right after reset
   `KFPVB_ASSERT_ALWAYS(a_rst_quiet, reset, !rsp_valid)
   // busy once an item is taken
   `KFPVB_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   // no new item while a result waits
   `KFPVB_ASSERT_NOW(a_one_at_a_time, rsp_valid, req_stall)
   // a taken result is not repeated
   `KFPVB_ASSERT_NEXT(a_single_rsp, rsp_valid && !rsp_stall, !rsp_valid)
   // stalled result holds
   `KFPVB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
                      rsp_valid && $stable(rsp_value) && $stable(rsp_skipped))

endmodule

bind kalman_filter_pos_vel_bias kfpvb_checker u_kfpvb_checker (.*);

// ===== dv/kalman_filter_pos_vel_bias_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_filter_pos_vel_bias_checker
// watches the request, result and register ports of the filter, keeps its
// own copy of estimate, covariance and noise registers, works out the
// expected result of every accepted request and compares it with the
// result items in order
// ----------------------------------------------------------------------------
module kalman_filter_pos_vel_bias_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] req_sample,
   input  logic [23:0]        req_delta_time,
   input  logic [30:0]        req_sensor_noise,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_value,
   input  logic               rsp_skipped,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_data,
   output int                 fail_count,
   output int                 pending,
   output int                 skip_count
);
   import kfpvb_pkg::*;

   typedef struct {
      logic signed [31:0] value;
      logic               skipped;
   } filter_out_type;

   filter_out_type     awaited[$];
   logic signed [31:0] est[3];
   logic signed [31:0] cov[9];
   logic [30:0]        q_pos, q_vel, q_bias;

   function automatic logic signed [31:0] clip(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // product with a power of dt, floored
   function automatic longint dmul(input longint p, input longint d, input int extra);
      return (p * d) >>> (24 + extra);
   endfunction

   task automatic clear_state();
      for (int i = 0; i < 3; i++) est[i] = '0;
      for (int i = 0; i < 9; i++) cov[i] = (i % 4 == 0) ? 32'sh0100_0000 : '0;
   endtask

   function automatic logic signed [31:0] propagate(input longint accel, input longint dt);
      longint d2, d3, d4, drv, v;
      longint p00, p01, p02, p10, p11, p12, p20, p21, p22;
      d2 = (dt * dt) >> 24;
      d3 = (d2 * dt) >> 24;
      d4 = (d3 * dt) >> 24;
      drv = accel - longint'(est[2]);
      v = est[1];
      p00 = cov[0]; p01 = cov[1]; p02 = cov[2];
      p10 = cov[3]; p11 = cov[4]; p12 = cov[5];
      p20 = cov[6]; p21 = cov[7]; p22 = cov[8];
      est[0] = clip(longint'(est[0]) + dmul(v, dt, 0) + dmul(drv, d2, 1));
      est[1] = clip(v + dmul(drv, dt, 0));
      cov[0] = clip(p00 + dmul(p01, dt, 0) + dmul(p10, dt, 0) + dmul(p11, d2, 0)
                    - dmul(p02, d2, 1) - dmul(p20, d2, 1)
                    - dmul(p12, d3, 1) - dmul(p21, d3, 1)
                    + dmul(p22, d4, 2) + longint'(q_pos));
      cov[1] = clip(p01 + dmul(p11, dt, 0) - dmul(p02, dt, 0) - dmul(p12, d2, 0)
                    - dmul(p21, d2, 1) + dmul(p22, d3, 1));
      cov[2] = clip(p02 + dmul(p12, dt, 0) - dmul(p22, d2, 1));
      cov[3] = clip(p10 + dmul(p11, dt, 0) - dmul(p20, dt, 0) - dmul(p21, d2, 0)
                    - dmul(p12, d2, 1) + dmul(p22, d3, 1));
      cov[4] = clip(p11 - dmul(p12, dt, 0) - dmul(p21, dt, 0) + dmul(p22, d2, 0)
                    + longint'(q_vel));
      cov[5] = clip(p12 - dmul(p22, dt, 0));
      cov[6] = clip(p20 + dmul(p21, dt, 0) - dmul(p22, d2, 1));
      cov[7] = clip(p21 - dmul(p22, dt, 0));
      cov[8] = clip(p22 + longint'(q_bias));
      return est[0];
   endfunction

   // scalar measurement update on state m; quotients truncate toward zero
   function automatic filter_out_type correct(input int m, input longint meas,
                                              input longint rn);
      filter_out_type     r;
      logic signed [31:0] old[9];
      longint             s, pim, pmj;
      r.value = clip(meas - longint'(est[m]));
      s = longint'(cov[m * 4]) + rn;
      r.skipped = (s == 0);
      if (s != 0) begin
         old = cov;
         for (int i = 0; i < 3; i++) begin
            pim = old[i * 3 + m];
            est[i] = clip(longint'(est[i]) + (pim * longint'(r.value)) / s);
            for (int j = 0; j < 3; j++) begin
               pmj = old[m * 3 + j];
               cov[i * 3 + j] = clip(longint'(old[i * 3 + j]) - (pim * pmj) / s);
            end
         end
      end
      return r;
   endfunction

   assign pending = awaited.size();

   always @(posedge clock) begin
      filter_out_type e;
      if (reset) begin
         awaited.delete();
         clear_state();
         q_pos <= '0;
         q_vel <= '0;
         q_bias <= '0;
         fail_count <= 0;
         skip_count <= 0;
      end else begin
         // register writes
         if (csr_write) begin
            case (csr_index)
               CSR_NOISE_POS:  q_pos <= csr_data;
               CSR_NOISE_VEL:  q_vel <= csr_data;
               CSR_NOISE_BIAS: q_bias <= csr_data;
               default: ;
            endcase
         end
         // result items against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               $display("%0t: unexpected result item value=%0d skipped=%0b",
                        $time, rsp_value, rsp_skipped);
               fail_count <= fail_count + 1;
            end else begin
               e = awaited.pop_front();
               if (e.value !== rsp_value || e.skipped !== rsp_skipped) begin
                  $display("%0t: mismatch expected value=%0d skipped=%0b actual value=%0d skipped=%0b",
                           $time, e.value, e.skipped, rsp_value, rsp_skipped);
                  fail_count <= fail_count + 1;
               end
               if (rsp_skipped) skip_count <= skip_count + 1;
            end
         end
         // accepted request items
         if (req_valid && !req_stall) begin
            e.value = '0;
            e.skipped = 1'b0;
            case (req_type)
               REQ_CLEAR:   clear_state();
               REQ_PREDICT: e.value = propagate(req_sample, req_delta_time);
               REQ_UPD_POS: e = correct(0, req_sample, req_sensor_noise);
               default:     e = correct(1, req_sample, req_sensor_noise);
            endcase
            awaited.push_back(e);
         end
      end
   end

endmodule

// ===== dv/kalman_filter_pos_vel_bias_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_filter_pos_vel_bias_test
// drives the filter with directed corner requests and then phases of random
// tracking sequences under changing noise settings; the checker predicts and
// compares every result item, this module gives the verdict
// ----------------------------------------------------------------------------
module kalman_filter_pos_vel_bias_test;
   import kfpvb_pkg::*;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int STALL_LIMIT = 20000;
   localparam int PHASES = 6;
   localparam int PHASE_ITEMS = 272;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_type = REQ_CLEAR;
   logic signed [31:0] req_sample = '0;
   logic [23:0]        req_delta_time = '0;
   logic [30:0]        req_sensor_noise = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_value;
   logic               rsp_skipped;
   logic               csr_write = 1'b0;
   logic [1:0]         csr_index = CSR_NOISE_POS;
   logic [30:0]        csr_data = '0;
   int                 fail_count, pending, skip_count;
   logic               gaps_on = 1'b1;
   int                 quiet_cycles = 0;
   int                 n_items = 0;

   always #5 clock = ~clock;

   kalman_filter_pos_vel_bias uut (.*);
   kalman_filter_pos_vel_bias_checker checker_i (.*);

   // result side back-pressure
   always @(posedge clock) rsp_stall <= gaps_on && ($urandom_range(99) < 28);

   // watchdog on lack of progress
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] t, input logic [31:0] smp,
                            input logic [23:0] dt, input logic [30:0] rn);
      if (gaps_on && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= t;
      req_sample <= smp;
      req_delta_time <= dt;
      req_sensor_noise <= rn;
      do @(posedge clock); while (req_stall);
      n_items++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_noise(input logic [30:0] np, input logic [30:0] nv,
                            input logic [30:0] nb);
      csr_write <= 1'b1;
      csr_index <= CSR_NOISE_POS;  csr_data <= np; @(posedge clock);
      csr_index <= CSR_NOISE_VEL;  csr_data <= nv; @(posedge clock);
      csr_index <= CSR_NOISE_BIAS; csr_data <= nb; @(posedge clock);
      // out of range index, must be ignored
      csr_index <= CSR_SPARE; csr_data <= 31'($urandom); @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // mostly plausible tracking traffic, some full range noise
   task automatic random_item();
      logic [1:0]  t;
      logic [31:0] smp;
      logic [23:0] dt;
      logic [30:0] rn;
      int          pick;
      pick = $urandom_range(99);
      t = (pick < 4) ? REQ_CLEAR : (pick < 50) ? REQ_PREDICT :
          (pick < 75) ? REQ_UPD_POS : REQ_UPD_VEL;
      if ($urandom_range(99) < 75) begin
         smp = 32'($urandom_range(0, 1 << 23)) - 32'(1 << 22);
         dt = 24'($urandom_range(1, 1 << 20));
         rn = 31'($urandom_range(0, 1 << 26));
      end else begin
         smp = $urandom;
         dt = 24'($urandom);
         rn = 31'($urandom);
      end
      if ($urandom_range(99) < 8) rn = '0;
      send_item(t, smp, dt, rn);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners with zero process noise
      set_noise('0, '0, '0);
      send_item(REQ_PREDICT, 32'sh7fffffff, 24'hffffff, '0);
      send_item(REQ_PREDICT, 32'sh80000000, 24'hffffff, '0);
      send_item(REQ_PREDICT, 32'sh00010000, 24'h000000, '0);
      send_item(REQ_CLEAR, 32'shffffffff, 24'hffffff, 31'h7fffffff);
      // zero innovation variance: second zero-noise update on the same state
      send_item(REQ_UPD_POS, 32'sh00050000, '0, '0);
      send_item(REQ_UPD_POS, 32'sh00030000, '0, '0);
      send_item(REQ_UPD_VEL, 32'shfffe0000, '0, '0);
      send_item(REQ_UPD_VEL, 32'sh00020000, '0, '0);
      send_item(REQ_PREDICT, 32'sh00008000, 24'h010000, '0);
      send_item(REQ_UPD_POS, 32'sh7fffffff, '0, 31'h7fffffff);
      send_item(REQ_UPD_VEL, 32'sh80000000, '0, 31'h7fffffff);
      send_item(REQ_CLEAR, '0, '0, '0);
      send_item(REQ_UPD_POS, 32'sh80000000, 24'hffffff, 31'h0000001);
      send_item(REQ_UPD_VEL, 32'sh7fffffff, 24'hffffff, 31'h0000001);
      send_item(REQ_PREDICT, 32'sh7fffffff, 24'h800000, 31'h7fffffff);
      wait_idle();

      // largest noise to push the covariance into saturation
      set_noise(31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
      send_item(REQ_CLEAR, '0, '0, '0);
      repeat (4) send_item(REQ_PREDICT, 32'sh80000000, 24'hffffff, '0);
      send_item(REQ_UPD_POS, 32'sh12345678, '0, 31'h7fffffff);
      send_item(REQ_UPD_VEL, 32'shedcba987, '0, '0);
      wait_idle();

      // random phases, each under its own noise setting
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: set_noise('0, '0, '0);
            1: set_noise(31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
            2: set_noise(31'($urandom), 31'($urandom), 31'($urandom));
            default: set_noise(31'($urandom_range(0, 1 << 22)),
                               31'($urandom_range(0, 1 << 22)),
                               31'($urandom_range(0, 1 << 20)));
         endcase
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // in phase 3, one long run without idling on either side
            gaps_on <= !(ph == 3);
            random_item();
         end
         wait_idle();
      end
      gaps_on <= 1'b1;

      repeat (50) @(posedge clock);
      $display("covered %0d request items over %0d noise phases, %0d skipped corrections",
               n_items, PHASES + 2, skip_count);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/kfpvb_pkg.sv
sv/kfpvb_mul.sv
sv/kfpvb_div.sv
sv/kalman_filter_pos_vel_bias.sv
sv/kfpvb_checker.sv
dv/kalman_filter_pos_vel_bias_checker.sv
dv/kalman_filter_pos_vel_bias_test.sv
